@@ rtl/core/plbc_pkg.sv @@
package plbc_pkg;

   localparam int unsigned PLBC_NAME_MAX        = 30;
   localparam int unsigned PLBC_COUNT_WIDTH     = 16;
   localparam int unsigned PLBC_INDEL_LEN_WIDTH = 16;

   localparam int unsigned PLBC_OUT_COUNT_WIDTH = 16;
   localparam int unsigned PLBC_POS_WIDTH       = 32;
   localparam int unsigned PLBC_NUM_COUNTERS    = 8;

   localparam logic [7:0] PLBC_CHAR_TAB   = 8'h09;
   localparam logic [7:0] PLBC_CHAR_NL    = 8'h0A;
   localparam logic [7:0] PLBC_CHAR_STAR  = 8'h2A;
   localparam logic [7:0] PLBC_CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] PLBC_CHAR_COMMA = 8'h2C;
   localparam logic [7:0] PLBC_CHAR_MINUS = 8'h2D;
   localparam logic [7:0] PLBC_CHAR_DOT   = 8'h2E;
   localparam logic [7:0] PLBC_CHAR_ZERO  = 8'h30;
   localparam logic [7:0] PLBC_CHAR_NINE  = 8'h39;
   localparam logic [7:0] PLBC_CHAR_UP_A  = 8'h41;
   localparam logic [7:0] PLBC_CHAR_UP_C  = 8'h43;
   localparam logic [7:0] PLBC_CHAR_UP_G  = 8'h47;
   localparam logic [7:0] PLBC_CHAR_UP_N  = 8'h4E;
   localparam logic [7:0] PLBC_CHAR_UP_T  = 8'h54;
   localparam logic [7:0] PLBC_CHAR_CARET = 8'h5E;
   localparam logic [7:0] PLBC_CHAR_LO_A  = 8'h61;
   localparam logic [7:0] PLBC_CHAR_LO_C  = 8'h63;
   localparam logic [7:0] PLBC_CHAR_LO_G  = 8'h67;
   localparam logic [7:0] PLBC_CHAR_LO_T  = 8'h74;

   // Counter slots: A0 C1 T2 G3 on the forward strand, plus four for reverse.
   localparam logic [2:0] PLBC_SLOT_FWD_A = 3'd0;
   localparam logic [2:0] PLBC_SLOT_FWD_C = 3'd1;
   localparam logic [2:0] PLBC_SLOT_FWD_T = 3'd2;
   localparam logic [2:0] PLBC_SLOT_FWD_G = 3'd3;
   localparam logic [2:0] PLBC_SLOT_REV_A = 3'd4;
   localparam logic [2:0] PLBC_SLOT_REV_C = 3'd5;
   localparam logic [2:0] PLBC_SLOT_REV_T = 3'd6;
   localparam logic [2:0] PLBC_SLOT_REV_G = 3'd7;

   typedef enum logic [3:0] {
      PH_CHROM      = 4'd0,
      PH_POS        = 4'd1,
      PH_POS_SKIP   = 4'd2,
      PH_REF        = 4'd3,
      PH_REF_SKIP   = 4'd4,
      PH_DEPTH_SKIP = 4'd5,
      PH_PILE       = 4'd6,
      PH_INDEL_NUM  = 4'd7,
      PH_INDEL_SKIP = 4'd8,
      PH_SKIP_ONE   = 4'd9,
      PH_TO_NL      = 4'd10
   } plbc_phase_type;

   typedef struct packed {
      logic [PLBC_POS_WIDTH-1:0]       line_position;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] fwd_a;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] fwd_c;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] fwd_g;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] fwd_t;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] rev_a;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] rev_c;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] rev_g;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] rev_t;
      logic [PLBC_OUT_COUNT_WIDTH-1:0] deletion_total;
      logic                            name_truncated;
   } plbc_line_result_type;

   function automatic logic plbc_is_digit(input logic [7:0] c);
      return (c >= PLBC_CHAR_ZERO) && (c <= PLBC_CHAR_NINE);
   endfunction

   function automatic logic [2:0] plbc_base_slot(input logic [7:0] c);
      return {c[5], c[2:1]};
   endfunction

endpackage

@@ rtl/core/plbc_stream_if.sv @@
interface plbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface plbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] line_position;
   logic [15:0] fwd_a;
   logic [15:0] fwd_c;
   logic [15:0] fwd_g;
   logic [15:0] fwd_t;
   logic [15:0] rev_a;
   logic [15:0] rev_c;
   logic [15:0] rev_g;
   logic [15:0] rev_t;
   logic [15:0] deletion_total;
   logic        name_truncated;

   modport source (
      output valid, output line_position,
      output fwd_a, output fwd_c, output fwd_g, output fwd_t,
      output rev_a, output rev_c, output rev_g, output rev_t,
      output deletion_total, output name_truncated,
      input ready
   );
   modport sink (
      input valid, input line_position,
      input fwd_a, input fwd_c, input fwd_g, input fwd_t,
      input rev_a, input rev_c, input rev_g, input rev_t,
      input deletion_total, input name_truncated,
      output ready
   );
endinterface

@@ rtl/core/plbc_line_parser.sv @@
module plbc_line_parser
   import plbc_pkg::*;
#(
   parameter int unsigned NAME_MAX        = PLBC_NAME_MAX,
   parameter int unsigned COUNT_WIDTH     = PLBC_COUNT_WIDTH,
   parameter int unsigned INDEL_LEN_WIDTH = PLBC_INDEL_LEN_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_take,
   input  logic [7:0]           byte_data,
   output logic                 line_done,
   output plbc_line_result_type line_result
);

   localparam int unsigned NameLenWidth = $clog2(NAME_MAX + 1);

   plbc_phase_type             phase_ff, phase_in;
   logic [PLBC_POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0]     count_ff [PLBC_NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0]     count_in [PLBC_NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0]     del_ff, del_in;
   logic [1:0]                 ref_ff, ref_in;
   logic                       ref_n_ff, ref_n_in;
   logic [INDEL_LEN_WIDTH-1:0] skip_ff, skip_in;
   logic [NameLenWidth-1:0]    name_len_ff, name_len_in;
   logic                       trunc_ff, trunc_in;

   logic [PLBC_POS_WIDTH+3:0]  pos_mul;
   logic [INDEL_LEN_WIDTH+3:0] skip_mul;
   logic [INDEL_LEN_WIDTH-1:0] skip_dec;
   logic                       do_pile;
   logic                       clear_line;
   logic                       bump;
   logic [2:0]                 bump_slot;
   logic [31:0]                count_wide [PLBC_NUM_COUNTERS];
   logic [31:0]                del_wide;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
   endfunction

   assign pos_mul = ({4'd0, pos_ff} << 3) + ({4'd0, pos_ff} << 1)
                  + (PLBC_POS_WIDTH+4)'(byte_data[3:0]);
   assign skip_mul = ({4'd0, skip_ff} << 3) + ({4'd0, skip_ff} << 1)
                   + (INDEL_LEN_WIDTH+4)'(byte_data[3:0]);
   assign skip_dec = skip_ff - 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      del_in      = del_ff;
      ref_in      = ref_ff;
      ref_n_in    = ref_n_ff;
      skip_in     = skip_ff;
      name_len_in = name_len_ff;
      trunc_in    = trunc_ff;
      for (int i = 0; i < PLBC_NUM_COUNTERS; i++) begin
         count_in[i] = count_ff[i];
      end
      do_pile    = 1'b0;
      clear_line = 1'b0;
      line_done  = 1'b0;
      bump       = 1'b0;
      bump_slot  = PLBC_SLOT_FWD_A;

      if (byte_take) begin
         case (phase_ff)
            PH_CHROM: begin
               if (byte_data == PLBC_CHAR_TAB) begin
                  phase_in = PH_POS;
               end else if (name_len_ff >= NameLenWidth'(NAME_MAX)) begin
                  trunc_in = 1'b1;
               end else begin
                  name_len_in = name_len_ff + 1'b1;
               end
            end
            PH_POS: begin
               if (plbc_is_digit(byte_data)) begin
                  pos_in = (pos_mul[PLBC_POS_WIDTH+3:PLBC_POS_WIDTH] != 4'd0)
                         ? {PLBC_POS_WIDTH{1'b1}} : pos_mul[PLBC_POS_WIDTH-1:0];
               end else if (byte_data == PLBC_CHAR_TAB) begin
                  phase_in = PH_REF;
               end else begin
                  phase_in = PH_POS_SKIP;
               end
            end
            PH_POS_SKIP: begin
               if (byte_data == PLBC_CHAR_TAB) begin
                  phase_in = PH_REF;
               end
            end
            PH_REF: begin
               ref_in   = byte_data[2:1];
               ref_n_in = (byte_data == PLBC_CHAR_UP_N);
               phase_in = PH_REF_SKIP;
            end
            PH_REF_SKIP: begin
               if (byte_data == PLBC_CHAR_TAB) begin
                  phase_in = PH_DEPTH_SKIP;
               end
            end
            PH_DEPTH_SKIP: begin
               if (byte_data == PLBC_CHAR_TAB) begin
                  phase_in = PH_PILE;
               end
            end
            PH_INDEL_NUM: begin
               if (plbc_is_digit(byte_data)) begin
                  skip_in = (skip_mul[INDEL_LEN_WIDTH+3:INDEL_LEN_WIDTH] != 4'd0)
                          ? {INDEL_LEN_WIDTH{1'b1}} : skip_mul[INDEL_LEN_WIDTH-1:0];
               end else if (skip_ff == '0) begin
                  phase_in = PH_PILE;
                  do_pile  = 1'b1;
               end else begin
                  skip_in  = skip_dec;
                  phase_in = (skip_dec == '0) ? PH_PILE : PH_INDEL_SKIP;
               end
            end
            PH_INDEL_SKIP: begin
               if (skip_ff != '0) begin
                  skip_in = skip_dec;
               end
               if ((skip_ff == '0) || (skip_dec == '0)) begin
                  phase_in = PH_PILE;
               end
            end
            PH_SKIP_ONE: begin
               phase_in = PH_PILE;
            end
            PH_TO_NL: begin
               if (byte_data == PLBC_CHAR_NL) begin
                  line_done  = 1'b1;
                  clear_line = 1'b1;
               end
            end
            PH_PILE: begin
               do_pile = 1'b1;
            end
            default: begin
               clear_line = 1'b1;
            end
         endcase

         if (do_pile) begin
            case (byte_data)
               PLBC_CHAR_NL: begin
                  line_done  = 1'b1;
                  clear_line = 1'b1;
               end
               PLBC_CHAR_TAB: begin
                  phase_in = PH_TO_NL;
               end
               PLBC_CHAR_STAR: begin
                  del_in = sat_inc(del_ff);
               end
               PLBC_CHAR_PLUS, PLBC_CHAR_MINUS: begin
                  skip_in  = '0;
                  phase_in = PH_INDEL_NUM;
               end
               PLBC_CHAR_DOT: begin
                  bump      = !ref_n_ff;
                  bump_slot = {1'b0, ref_ff};
               end
               PLBC_CHAR_COMMA: begin
                  bump      = !ref_n_ff;
                  bump_slot = {1'b1, ref_ff};
               end
               PLBC_CHAR_CARET: begin
                  phase_in = PH_SKIP_ONE;
               end
               PLBC_CHAR_UP_A, PLBC_CHAR_UP_C, PLBC_CHAR_UP_G, PLBC_CHAR_UP_T,
               PLBC_CHAR_LO_A, PLBC_CHAR_LO_C, PLBC_CHAR_LO_G, PLBC_CHAR_LO_T: begin
                  bump      = 1'b1;
                  bump_slot = plbc_base_slot(byte_data);
               end
               default: begin
               end
            endcase
         end

         if (bump) begin
            count_in[bump_slot] = sat_inc(count_ff[bump_slot]);
         end

         if (clear_line) begin
            phase_in    = PH_CHROM;
            pos_in      = '0;
            del_in      = '0;
            skip_in     = '0;
            name_len_in = '0;
            trunc_in    = 1'b0;
            for (int i = 0; i < PLBC_NUM_COUNTERS; i++) begin
               count_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CHROM;
         pos_ff      <= '0;
         del_ff      <= '0;
         ref_ff      <= '0;
         ref_n_ff    <= 1'b0;
         skip_ff     <= '0;
         name_len_ff <= '0;
         trunc_ff    <= 1'b0;
         for (int i = 0; i < PLBC_NUM_COUNTERS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         del_ff      <= del_in;
         ref_ff      <= ref_in;
         ref_n_ff    <= ref_n_in;
         skip_ff     <= skip_in;
         name_len_ff <= name_len_in;
         trunc_ff    <= trunc_in;
         for (int i = 0; i < PLBC_NUM_COUNTERS; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PLBC_NUM_COUNTERS; i++) begin
         count_wide[i] = 32'(count_ff[i]);
      end
      del_wide = 32'(del_ff);
   end

   assign line_result.line_position  = pos_ff;
   assign line_result.fwd_a          = count_wide[PLBC_SLOT_FWD_A][15:0];
   assign line_result.fwd_c          = count_wide[PLBC_SLOT_FWD_C][15:0];
   assign line_result.fwd_g          = count_wide[PLBC_SLOT_FWD_G][15:0];
   assign line_result.fwd_t          = count_wide[PLBC_SLOT_FWD_T][15:0];
   assign line_result.rev_a          = count_wide[PLBC_SLOT_REV_A][15:0];
   assign line_result.rev_c          = count_wide[PLBC_SLOT_REV_C][15:0];
   assign line_result.rev_g          = count_wide[PLBC_SLOT_REV_G][15:0];
   assign line_result.rev_t          = count_wide[PLBC_SLOT_REV_T][15:0];
   assign line_result.deletion_total = del_wide[15:0];
   assign line_result.name_truncated = trunc_ff;

endmodule

@@ rtl/core/pileup_line_base_counter.sv @@
// Pileup line counter: takes one byte of pileup text per item and may accept a new
// item in every cycle. Each byte updates the line state in the cycle in which it is
// accepted; the newline that ends a line loads its position, the eight strand counts,
// the deletion count and the truncation flag into the result register, where they
// appear in the next cycle. The only back-pressure comes from that single result
// register: req_if.ready falls only while a finished line waits in it and the sink
// does not take it in the same cycle.
module pileup_line_base_counter
   import plbc_pkg::*;
#(
   parameter int unsigned NAME_MAX        = PLBC_NAME_MAX,
   parameter int unsigned COUNT_WIDTH     = PLBC_COUNT_WIDTH,
   parameter int unsigned INDEL_LEN_WIDTH = PLBC_INDEL_LEN_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   plbc_req_if.sink    req_if,
   plbc_rsp_if.source  rsp_if
);

   logic                 byte_take;
   logic                 line_done;
   plbc_line_result_type line_result;
   logic                 rsp_valid_ff, rsp_valid_in;
   plbc_line_result_type rsp_data_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign byte_take    = req_if.valid && req_if.ready;

   plbc_line_parser #(
      .NAME_MAX        (NAME_MAX),
      .COUNT_WIDTH     (COUNT_WIDTH),
      .INDEL_LEN_WIDTH (INDEL_LEN_WIDTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (byte_take),
      .byte_data   (req_if.in_byte),
      .line_done   (line_done),
      .line_result (line_result)
   );

   always_comb begin
      if (line_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_done) begin
         rsp_data_ff <= line_result;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.line_position  = rsp_data_ff.line_position;
   assign rsp_if.fwd_a          = rsp_data_ff.fwd_a;
   assign rsp_if.fwd_c          = rsp_data_ff.fwd_c;
   assign rsp_if.fwd_g          = rsp_data_ff.fwd_g;
   assign rsp_if.fwd_t          = rsp_data_ff.fwd_t;
   assign rsp_if.rev_a          = rsp_data_ff.rev_a;
   assign rsp_if.rev_c          = rsp_data_ff.rev_c;
   assign rsp_if.rev_g          = rsp_data_ff.rev_g;
   assign rsp_if.rev_t          = rsp_data_ff.rev_t;
   assign rsp_if.deletion_total = rsp_data_ff.deletion_total;
   assign rsp_if.name_truncated = rsp_data_ff.name_truncated;

endmodule
